[src/bvd_pkg.sv]
// bvd_pkg: shared widths, register indexes and types for the byte vector
// distance core. No dependencies.
package bvd_pkg;

	// Field widths
	localparam int CODE_W     = 8;
	localparam int BUS_W      = 64;
	localparam int CNT_W      = 4;
	localparam int DIST_W     = 29;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// One lane term: 9x9 signed product, range -16256..65025
	localparam int TERM_W = 18;
	// Sum of up to eight lane terms, range -130048..520200
	localparam int SUM_W  = 20;
	// Running sum kept modulo 2^DIST_W, only the low bits are ever shown
	localparam int ACC_W  = DIST_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_METRIC       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_CODES = 2'd1;

	// Register file contents as seen by the lanes
	typedef struct packed {
		logic metric;        // 0 inner product, 1 squared L2
		logic signed_codes;  // bytes carry a +128 offset
	} bvd_cfg_t;

	// Control that travels with a beat between pipeline stages
	typedef struct packed {
		logic valid;
		logic last;
	} bvd_beat_t;

endpackage

[src/bvd_intf.sv]
// bvd_intf: stream, result and configuration channel interfaces of the
// byte vector distance core. Depends on bvd_pkg.
interface bvd_vec_if import bvd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [BUS_W-1:0]        a_bytes;
	logic [BUS_W-1:0]        b_bytes;
	logic [CNT_W-1:0]        lane_count;
	logic                    last;

	modport source (output valid, a_bytes, b_bytes, lane_count, last, input ready);
	modport sink   (input valid, a_bytes, b_bytes, lane_count, last, output ready);
endinterface

interface bvd_dist_if import bvd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DIST_W-1:0] distance;

	modport source (output valid, distance, input ready);
	modport sink   (input valid, distance, output ready);
endinterface

interface bvd_cfg_if import bvd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[src/bvd_lane.sv]
// bvd_lane: one byte-pair lane, forms the inner product or squared
// difference term and registers it. Depends on bvd_pkg.
module bvd_lane import bvd_pkg::*; (
	input  logic                     clk,
	input  logic                     load,
	input  logic                     active,
	input  bvd_cfg_t                 cfg,
	input  logic [CODE_W-1:0]        a_code,
	input  logic [CODE_W-1:0]        b_code,
	output logic signed [TERM_W-1:0] term_s1
);

	logic signed [CODE_W:0]   x;
	logic signed [CODE_W:0]   y;
	logic signed [TERM_W-1:0] xw;
	logic signed [TERM_W-1:0] yw;
	logic signed [TERM_W-1:0] prod;

	// Operand select: difference for L2, offset-removed or plain codes otherwise
	always_comb begin
		if (cfg.metric) begin
			x = $signed({1'b0, a_code}) - $signed({1'b0, b_code});
			y = x;
		end else if (cfg.signed_codes) begin
			// code - 128 is the code with its top bit flipped, sign extended
			x = $signed({~a_code[CODE_W-1], ~a_code[CODE_W-1], a_code[CODE_W-2:0]});
			y = $signed({~b_code[CODE_W-1], ~b_code[CODE_W-1], b_code[CODE_W-2:0]});
		end else begin
			x = $signed({1'b0, a_code});
			y = $signed({1'b0, b_code});
		end
		xw   = x;
		yw   = y;
		prod = xw * yw;
	end

	// Term register, lanes above the beat's lane count add nothing
	always_ff @(posedge clk) begin
		if (load) begin
			term_s1 <= active ? prod : '0;
		end
	end

endmodule

[src/bvd_merge.sv]
// bvd_merge: sums the lane terms of a beat, folds them into the running sum
// and holds the result register. Depends on bvd_pkg and bvd_intf.
module bvd_merge import bvd_pkg::*; #(
	parameter int LANES = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bvd_beat_t                s1,
	input  logic signed [TERM_W-1:0] terms [LANES],
	output logic                     s1_ready,
	bvd_dist_if.source               result
);

	bvd_beat_t                s2_q;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [SUM_W-1:0]  lane_sum;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  total;
	logic signed [DIST_W-1:0] dist_q;
	logic                     out_valid_q;
	logic                     acc_adv;
	logic                     s2_take;

	// Lane merge: add the registered terms of one beat
	always_comb begin
		lane_sum = '0;
		for (int k = 0; k < LANES; k++) begin
			lane_sum = lane_sum + SUM_W'(terms[k]);
		end
	end

	// Only a last beat needs the result register to be free
	assign acc_adv  = s2_q.valid && (!s2_q.last || !out_valid_q || result.ready);
	assign s2_take  = !s2_q.valid || acc_adv;
	assign s1_ready = s2_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_q <= '0;
		end else if (s2_take) begin
			s2_q.valid <= s1.valid;
			if (s1.valid) begin
				s2_q.last <= s1.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && s1.valid) begin
			sum_s2 <= lane_sum;
		end
	end

	// Running sum, wraps modulo 2^ACC_W
	assign total = acc_q + {{(ACC_W-SUM_W){sum_s2[SUM_W-1]}}, sum_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (acc_adv) begin
			acc_q <= s2_q.last ? '0 : total;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_adv && s2_q.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_adv && s2_q.last) begin
			dist_q <= total;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = dist_q;

	// The running sum starts over after a vector is closed
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_adv && s2_q.last) |=> (acc_q == '0))
		else $error("running sum not cleared after last beat");

	// A waiting result is never overwritten or dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(dist_q)))
		else $error("pending result lost");

	// A held stage-two beat stays put while the merge stage is blocked
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_q.valid && !acc_adv) |=> (s2_q.valid && $stable(sum_s2) && $stable(s2_q.last)))
		else $error("stage two beat changed while stalled");

endmodule

[src/byte_vector_distance_core.sv]
// byte_vector_distance_core: top level of the int8 inner product / squared
// L2 distance engine. Depends on bvd_pkg, bvd_intf, bvd_lane, bvd_merge.
//
//  channel   | role   | payload                                   | beat when
//  ----------+--------+-------------------------------------------+-------------
//  vectors   | sink   | a_bytes, b_bytes, lane_count, last        | valid&ready
//  result    | source | distance (signed 29 bit)                  | valid&ready
//  cfg       | sink   | index (0 metric, 1 signed_codes), data[0] | valid&ready
//
// One vector beat is taken every cycle while no last beat stalls; the
// result of a last beat is shown after the lane terms are registered, then
// the lane merge, then the running sum into the result register.
// The rate is set by one multiplier per lane and a single accumulator.
// Reset clears the configuration registers, the running sum and all valids.
// Non-last beats flow on while a result waits; only a last beat stalls
// behind an untaken result. cfg is always ready.
module byte_vector_distance_core import bvd_pkg::*; #(
	parameter int LANES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	bvd_cfg_if.sink      cfg,
	bvd_vec_if.sink      vectors,
	bvd_dist_if.source   result
);

	bvd_cfg_t                 cfg_q;
	bvd_beat_t                s1_q;
	logic                     s1_ready;
	logic                     s1_take;
	logic                     load;
	logic signed [TERM_W-1:0] terms [LANES];

	// Configuration registers, indexes beyond the list are ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_METRIC:       cfg_q.metric       <= cfg.data[0];
				REG_SIGNED_CODES: cfg_q.signed_codes <= cfg.data[0];
				default:          ;
			endcase
		end
	end

	// Stage one control
	assign s1_take       = !s1_q.valid || s1_ready;
	assign vectors.ready = s1_take;
	assign load          = vectors.valid && s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (s1_take) begin
			s1_q.valid <= vectors.valid;
			if (vectors.valid) begin
				s1_q.last <= vectors.last;
			end
		end
	end

	// Lanes; a lane count above LANES covers every lane
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		bvd_lane u_lane (
			.clk     (clk),
			.load    (load),
			.active  (vectors.lane_count > CNT_W'(k)),
			.cfg     (cfg_q),
			.a_code  (vectors.a_bytes[k*CODE_W +: CODE_W]),
			.b_code  (vectors.b_bytes[k*CODE_W +: CODE_W]),
			.term_s1 (terms[k])
		);
	end

	bvd_merge #(
		.LANES (LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1       (s1_q),
		.terms    (terms),
		.s1_ready (s1_ready),
		.result   (result)
	);

endmodule

[bench/byte_vector_distance_core_test.sv]
// byte_vector_distance_core_test: self-checking bench for the int8 inner product /
// squared L2 distance core, with directed cases, random vectors and a long wrap run.
// Depends on bvd_pkg, bvd_intf and byte_vector_distance_core.
module byte_vector_distance_core_test import bvd_pkg::*; ();

	localparam int LANES          = 8;
	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_GAP        = 3;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_BEATS    = 12;
	localparam int WRAP_BEATS     = 1100;
	localparam int MAX_LINES      = 100;
	localparam int WATCHDOG_CYCLES = 400000;

	localparam logic METRIC_DOT = 1'b0;
	localparam logic METRIC_L2  = 1'b1;
	localparam int   OFFSET_BIAS = 128;

	// indexes past the end of the register list, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	bvd_vec_if  vectors();
	bvd_dist_if result();
	bvd_cfg_if  cfg();

	byte_vector_distance_core #(.LANES(LANES)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vectors (vectors),
		.result  (result)
	);

	// predictor state
	logic                     pred_metric;
	logic                     pred_offset_codes;
	logic [31:0]              pair_sum;
	logic signed [DIST_W-1:0] expected_distances[$];

	int unsigned mismatches = 0;
	bit          steady     = 1'b0;

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_LINES)
			$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// one lane's contribution under the current register values
	function automatic logic [31:0] code_term(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b);
		int x;
		int y;
		x = a;
		y = b;
		if (pred_metric == METRIC_L2)
			return (x - y) * (x - y);
		if (pred_offset_codes) begin
			x -= OFFSET_BIAS;
			y -= OFFSET_BIAS;
		end
		return x * y;
	endfunction

	// fold one accepted beat into the running sum, queue the distance on last
	function automatic void accumulate_beat(input logic [BUS_W-1:0] a, input logic [BUS_W-1:0] b,
			input logic [CNT_W-1:0] n, input logic lst);
		int unsigned lanes;
		lanes = (n > LANES) ? LANES : n;
		for (int k = 0; k < lanes; k++)
			pair_sum += code_term(a[CODE_W*k +: CODE_W], b[CODE_W*k +: CODE_W]);
		if (lst) begin
			expected_distances.push_back(pair_sum[DIST_W-1:0]);
			pair_sum = '0;
		end
	endfunction

	// one beat on the vector channel; valid stays up for the next caller
	task automatic send_beat(input logic [BUS_W-1:0] a, input logic [BUS_W-1:0] b,
			input logic [CNT_W-1:0] n, input logic lst);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			vectors.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vectors.valid      <= 1'b1;
		vectors.a_bytes    <= a;
		vectors.b_bytes    <= b;
		vectors.lane_count <= n;
		vectors.last       <= lst;
		do @(posedge clk); while (!vectors.ready);
		accumulate_beat(a, b, n, lst);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_METRIC:       pred_metric = data[0];
			REG_SIGNED_CODES: pred_offset_codes = data[0];
			default: ;
		endcase
	endtask

	// only called with the core idle; upper data bits are junk on purpose
	task automatic set_mode(input logic metric, input logic offset_codes);
		write_reg(REG_METRIC, {7'($urandom), metric});
		write_reg(REG_SIGNED_CODES, {7'($urandom), offset_codes});
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// stop sending, wait out every pending distance and the pipeline behind it
	task automatic drain();
		vectors.valid <= 1'b0;
		while (expected_distances.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [BUS_W-1:0] random_codes();
		logic [BUS_W-1:0] v;
		for (int k = 0; k < LANES; k++) begin
			case ($urandom_range(0, 7))
				0:       v[CODE_W*k +: CODE_W] = '0;
				1:       v[CODE_W*k +: CODE_W] = '1;
				2:       v[CODE_W*k +: CODE_W] = 8'(OFFSET_BIAS);
				default: v[CODE_W*k +: CODE_W] = 8'($urandom);
			endcase
		end
		return v;
	endfunction

	// mostly legal lane counts, now and then zero or above LANES
	function automatic logic [CNT_W-1:0] random_lanes();
		if ($urandom_range(0, 9) < 8)
			return CNT_W'($urandom_range(1, LANES));
		return CNT_W'($urandom_range(0, 15));
	endfunction

	// reset register values: unsigned inner product
	task automatic test_reset_defaults();
		send_beat('1, '1, 4'd8, 1'b1);
		send_beat(64'h0123_4567_89ab_cdef, '1, 4'd0, 1'b1);
		send_beat('1, '1, 4'd15, 1'b1);
		send_beat(64'hffff_ffff_ff03_0201, 64'haaaa_aaaa_aa05_0403, 4'd3, 1'b1);
		send_beat('0, '1, 4'd8, 1'b0);
		send_beat(64'h8080_8080_8080_8080, 64'hff00_ff00_ff00_ff00, 4'd8, 1'b1);
		drain();
	endtask

	// remaining register settings at the byte extremes
	task automatic test_register_modes();
		set_mode(METRIC_DOT, 1'b1);
		send_beat('0, '1, 4'd8, 1'b1);
		send_beat('0, '0, 4'd8, 1'b0);
		send_beat(64'h8080_8080_8080_8080, random_codes(), 4'd8, 1'b1);
		drain();
		set_mode(METRIC_L2, 1'b0);
		send_beat('0, '1, 4'd8, 1'b1);
		send_beat('1, '0, 4'd12, 1'b1);
		drain();
		set_mode(METRIC_L2, 1'b1);
		send_beat('1, '0, 4'd8, 1'b1);
		send_beat(random_codes(), random_codes(), 4'd5, 1'b1);
		drain();
	endtask

	// registers change while a vector pair is half through
	task automatic test_mid_vector_change();
		set_mode(METRIC_DOT, 1'b0);
		send_beat('1, 64'h0102_0304_0506_0708, 4'd8, 1'b0);
		drain();
		set_mode(METRIC_L2, 1'b0);
		send_beat('0, '1, 4'd4, 1'b0);
		drain();
		set_mode(METRIC_DOT, 1'b1);
		send_beat('0, '1, 4'd8, 1'b1);
		drain();
	endtask

	// random vector pairs of random length in every register setting
	task automatic test_random_vectors();
		int unsigned sent;
		int unsigned vec_len;
		logic [1:0]  mode;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			steady = (phase % 3 == 2);
			mode = (phase < 4) ? 2'(phase) : 2'($urandom);
			set_mode(mode[1], mode[0]);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				vec_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
				for (int i = 0; i < vec_len; i++)
					send_beat(random_codes(), random_codes(), random_lanes(), i == vec_len - 1);
				sent += vec_len;
			end
			// leave a pair open across the next register change now and then
			if ($urandom_range(0, 1))
				send_beat(random_codes(), random_codes(), random_lanes(), 1'b0);
			drain();
		end
		steady = 1'b0;
	endtask

	// one pair long enough to carry the sum past the top of the distance field
	task automatic test_long_vector_wrap();
		logic [BUS_W-1:0] a;
		logic [BUS_W-1:0] b;
		set_mode(METRIC_DOT, 1'b0);
		steady = 1'b1;
		for (int i = 0; i < WRAP_BEATS; i++) begin
			for (int k = 0; k < LANES; k++) begin
				a[CODE_W*k +: CODE_W] = 8'($urandom_range(250, 255));
				b[CODE_W*k +: CODE_W] = 8'($urandom_range(250, 255));
			end
			send_beat(a, b, 4'd8, i == WRAP_BEATS - 1);
		end
		drain();
		steady = 1'b0;
	endtask

	// result side: random stalls after each beat, compare against the queue
	initial begin : distance_sink
		int unsigned hold;
		logic signed [DIST_W-1:0] want;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		result.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (expected_distances.size() == 0) begin
					report_mismatch($sformatf("distance %0d with no vector pair closed", result.distance));
				end else begin
					want = expected_distances.pop_front();
					if (result.distance !== want)
						report_mismatch($sformatf("distance got %0d expected %0d",
							result.distance, want));
				end
				hold = draw_gap();
				if (hold != 0) begin
					result.ready <= 1'b0;
					repeat (hold) @(posedge clk);
					result.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		#(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : run_tests
		arst_n             = 1'b0;
		vectors.valid      = 1'b0;
		vectors.a_bytes    = '0;
		vectors.b_bytes    = '0;
		vectors.lane_count = '0;
		vectors.last       = 1'b0;
		cfg.valid          = 1'b0;
		cfg.index          = '0;
		cfg.data           = '0;
		pred_metric        = METRIC_DOT;
		pred_offset_codes  = 1'b0;
		pair_sum           = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_modes();
		test_mid_vector_change();
		test_random_vectors();
		test_long_vector_wrap();
		drain();

		if (mismatches == 0 && expected_distances.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
